FILE: rtl/keyed_entropy_word_derivation_defines.svh
// Assertion macros used by the RTL.
`ifndef KEYED_ENTROPY_WORD_DERIVATION_DEFINES_SVH
`define KEYED_ENTROPY_WORD_DERIVATION_DEFINES_SVH

// Same-cycle implication, checked on clk, off during reset.
`define KEWD_ASSERT_IMP(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("kewd assertion failed");

// Next-cycle implication, checked on clk, off during reset.
`define KEWD_ASSERT_NXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("kewd assertion failed");

`endif

FILE: rtl/kewd_pkg.sv
`default_nettype none

package kewd_pkg;

	localparam logic [63:0] SIP_C0 = 64'h736f6d6570736575;
	localparam logic [63:0] SIP_C1 = 64'h646f72616e646f6d;
	localparam logic [63:0] SIP_C2 = 64'h6c7967656e657261;
	localparam logic [63:0] SIP_C3 = 64'h7465646279746573;
	localparam logic [63:0] LEN_WORD = 64'd8 << 56;
	localparam logic [63:0] FIN_WORD = 64'hff;

	localparam logic [5:0] CREDIT_LOCKED = 6'd40;
	localparam logic [5:0] CREDIT_UNLOCKED = 6'd16;

	localparam int NUM_CELLS = 16;
	localparam int CELL_IDX_W = $clog2(NUM_CELLS);

	// two half-rounds per SipRound: message absorb, length absorb, finalization
	localparam logic [CELL_IDX_W-1:0] MSG_FIRST_CELL = CELL_IDX_W'(0);
	localparam logic [CELL_IDX_W-1:0] MSG_LAST_CELL = CELL_IDX_W'(3);
	localparam logic [CELL_IDX_W-1:0] LEN_FIRST_CELL = CELL_IDX_W'(4);
	localparam logic [CELL_IDX_W-1:0] LEN_LAST_CELL = CELL_IDX_W'(7);

	typedef enum logic [1:0] {
		REG_KEYED_MODE = 2'd0,
		REG_KEY_LOW = 2'd1,
		REG_KEY_HIGH = 2'd2
	} reg_idx_t;

	typedef struct packed {
		logic [63:0] v0;
		logic [63:0] v1;
		logic [63:0] v2;
		logic [63:0] v3;
		logic [63:0] msg;
		logic keyed;
		logic locked;
	} sip_item_t;

	typedef struct packed {
		logic half_b;
		logic pre_msg;
		logic post_msg;
		logic pre_len;
		logic post_fin;
	} cell_ctrl_t;

	function automatic logic [63:0] rotl64(input logic [63:0] x, input int unsigned b);
		return (x << b) | (x >> (64 - b));
	endfunction

	function automatic cell_ctrl_t cell_ctrl(input logic [CELL_IDX_W-1:0] idx);
		cell_ctrl_t c;
		c.half_b = idx[0];
		c.pre_msg = (idx == MSG_FIRST_CELL);
		c.post_msg = (idx == MSG_LAST_CELL);
		c.pre_len = (idx == LEN_FIRST_CELL);
		c.post_fin = (idx == LEN_LAST_CELL);
		return c;
	endfunction

endpackage

`default_nettype wire

FILE: rtl/kewd_cell.sv
`default_nettype none

module kewd_cell (
	input wire logic clk,
	input wire logic arst_n,
	input wire kewd_pkg::cell_ctrl_t ctrl,
	input wire logic in_valid,
	output logic in_ready,
	input wire kewd_pkg::sip_item_t in_data,
	output logic out_valid,
	input wire logic out_ready,
	output kewd_pkg::sip_item_t out_data
);

	logic valid_q;
	kewd_pkg::sip_item_t data_q;
	kewd_pkg::sip_item_t nxt;

	always_comb begin
		nxt = in_data;
		if (ctrl.pre_msg) begin
			nxt.v3 = nxt.v3 ^ nxt.msg;
		end
		if (ctrl.pre_len) begin
			nxt.v3 = nxt.v3 ^ kewd_pkg::LEN_WORD;
		end
		if (!ctrl.half_b) begin
			nxt.v0 = nxt.v0 + nxt.v1;
			nxt.v1 = kewd_pkg::rotl64(nxt.v1, 13) ^ nxt.v0;
			nxt.v0 = kewd_pkg::rotl64(nxt.v0, 32);
			nxt.v2 = nxt.v2 + nxt.v3;
			nxt.v3 = kewd_pkg::rotl64(nxt.v3, 16) ^ nxt.v2;
		end else begin
			nxt.v0 = nxt.v0 + nxt.v3;
			nxt.v3 = kewd_pkg::rotl64(nxt.v3, 21) ^ nxt.v0;
			nxt.v2 = nxt.v2 + nxt.v1;
			nxt.v1 = kewd_pkg::rotl64(nxt.v1, 17) ^ nxt.v2;
			nxt.v2 = kewd_pkg::rotl64(nxt.v2, 32);
		end
		if (ctrl.post_msg) begin
			nxt.v0 = nxt.v0 ^ nxt.msg;
		end
		if (ctrl.post_fin) begin
			nxt.v0 = nxt.v0 ^ kewd_pkg::LEN_WORD;
			nxt.v2 = nxt.v2 ^ kewd_pkg::FIN_WORD;
		end
	end

	assign in_ready = !valid_q || out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (in_ready) begin
			valid_q <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			data_q <= nxt;
		end
	end

	assign out_valid = valid_q;
	assign out_data = data_q;

endmodule

`default_nettype wire

FILE: rtl/keyed_entropy_word_derivation.sv
// Derives one 64-bit entropy word and a credit per transaction. In keyed mode the word is
// SipHash-2-4 of the 8-byte message {phase_bits, tick} under key {key_high, key_low}; in
// bypass mode it is {phase_bits, tick ^ phase_bits}. The hash runs down a row of 16
// half-round cells followed by an output register: one transaction is taken per cycle
// unless a stall has backed up the row, and each result passes every cell register, then
// the output register. Each cell has its own ready, so a stall at the output backs up cell
// by cell and empty cells keep accepting. Keys and mode are sampled as a transaction enters.
`default_nettype none

`include "keyed_entropy_word_derivation_defines.svh"

module keyed_entropy_word_derivation (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic s_tvalid,
	output logic s_tready,
	input wire logic [63:0] s_tdata, // tick[31:0], phase_bits[63:32]
	input wire logic s_tuser, // locked
	output logic m_tvalid,
	input wire logic m_tready,
	output logic [71:0] m_tdata, // entropy_word[63:0], credit_bits[69:64], zero pad
	input wire logic cfg_we,
	input wire logic [1:0] cfg_index,
	input wire logic [63:0] cfg_data
);

	localparam int N = kewd_pkg::NUM_CELLS;

	logic keyed_q;
	logic [63:0] key_low_q;
	logic [63:0] key_high_q;

	logic c_valid [0:N];
	logic c_ready [0:N];
	kewd_pkg::sip_item_t c_data [0:N];

	logic out_valid_q;
	logic [71:0] out_data_q;
	kewd_pkg::sip_item_t last;
	logic [63:0] word;
	logic [5:0] credit;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			keyed_q <= 1'b0;
			key_low_q <= '0;
			key_high_q <= '0;
		end else if (cfg_we) begin
			case (kewd_pkg::reg_idx_t'(cfg_index))
				kewd_pkg::REG_KEYED_MODE: keyed_q <= cfg_data[0];
				kewd_pkg::REG_KEY_LOW: key_low_q <= cfg_data;
				kewd_pkg::REG_KEY_HIGH: key_high_q <= cfg_data;
				default: ;
			endcase
		end
	end

	always_comb begin
		c_data[0].v0 = key_low_q ^ kewd_pkg::SIP_C0;
		c_data[0].v1 = key_high_q ^ kewd_pkg::SIP_C1;
		c_data[0].v2 = key_low_q ^ kewd_pkg::SIP_C2;
		c_data[0].v3 = key_high_q ^ kewd_pkg::SIP_C3;
		c_data[0].msg = s_tdata;
		c_data[0].keyed = keyed_q;
		c_data[0].locked = s_tuser;
	end

	assign c_valid[0] = s_tvalid;
	assign s_tready = c_ready[0];

	for (genvar i = 0; i < N; i++) begin : g_cell
		kewd_cell u_cell (
			.clk(clk),
			.arst_n(arst_n),
			.ctrl(kewd_pkg::cell_ctrl(kewd_pkg::CELL_IDX_W'(i))),
			.in_valid(c_valid[i]),
			.in_ready(c_ready[i]),
			.in_data(c_data[i]),
			.out_valid(c_valid[i+1]),
			.out_ready(c_ready[i+1]),
			.out_data(c_data[i+1])
		);
	end

	assign c_ready[N] = !out_valid_q || m_tready;
	assign last = c_data[N];

	always_comb begin
		if (last.keyed) begin
			word = last.v0 ^ last.v1 ^ last.v2 ^ last.v3;
		end else begin
			word = {last.msg[63:32], last.msg[31:0] ^ last.msg[63:32]};
		end
		credit = last.locked ? kewd_pkg::CREDIT_LOCKED : kewd_pkg::CREDIT_UNLOCKED;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (c_ready[N]) begin
			out_valid_q <= c_valid[N];
		end
	end

	always_ff @(posedge clk) begin
		if (c_ready[N] && c_valid[N]) begin
			out_data_q <= {2'b00, credit, word};
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata = out_data_q;

	`KEWD_ASSERT_IMP(a_credit_legal, m_tvalid,
		m_tdata[69:64] == kewd_pkg::CREDIT_LOCKED || m_tdata[69:64] == kewd_pkg::CREDIT_UNLOCKED)
	`KEWD_ASSERT_IMP(a_empty_out_takes, !out_valid_q, c_ready[N])
	`KEWD_ASSERT_NXT(a_accept_enters_cell, s_tvalid && s_tready, c_valid[1])
	`KEWD_ASSERT_NXT(a_mode_write, cfg_we && cfg_index == kewd_pkg::REG_KEYED_MODE,
		keyed_q == $past(cfg_data[0]))

endmodule

`default_nettype wire

FILE: sim/tb.sv
`timescale 1ns / 1ps

module tb;

	localparam int CYCLE_LIMIT = 1000000;
	localparam int TAIL_CYCLES = 40;
	localparam int RANDOM_PER_PHASE = 250;

	// index with no register behind it
	localparam logic [1:0] REG_NONE = 2'd3;

	localparam logic [63:0] IV0 = 64'h736f6d6570736575;
	localparam logic [63:0] IV1 = 64'h646f72616e646f6d;
	localparam logic [63:0] IV2 = 64'h6c7967656e657261;
	localparam logic [63:0] IV3 = 64'h7465646279746573;
	localparam logic [63:0] LENGTH_BLOCK = 64'h0800000000000000;
	localparam logic [63:0] FINAL_XOR = 64'h00000000000000ff;
	localparam logic [5:0] CREDIT_HI = 6'd40;
	localparam logic [5:0] CREDIT_LO = 6'd16;

	typedef enum logic [1:0] {
		RX_OPEN,
		RX_COIN,
		RX_SPARSE,
		RX_LONG
	} rx_style_t;

	typedef struct packed {
		logic [31:0] tick;
		logic [31:0] phase_bits;
		logic locked;
	} beacon_t;

	typedef struct packed {
		logic [63:0] word;
		logic [5:0] credit;
	} entropy_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic s_tvalid = 1'b0;
	logic s_tready;
	logic [63:0] s_tdata = '0;
	logic s_tuser = 1'b0;
	logic m_tvalid;
	logic m_tready = 1'b0;
	logic [71:0] m_tdata;
	logic cfg_we = 1'b0;
	logic [1:0] cfg_index = '0;
	logic [63:0] cfg_data = '0;

	logic cfg_keyed = 1'b0;
	logic [63:0] cfg_k0 = '0;
	logic [63:0] cfg_k1 = '0;

	beacon_t beacon_q[$];
	entropy_t entropy_expect_q[$];
	beacon_t beacon_cur;
	int beacons_queued = 0;
	int words_seen = 0;
	int error_count = 0;
	int cycle_count = 0;
	int burst_left = 0;
	int gap_left = 0;
	rx_style_t rx_style = RX_OPEN;
	int rx_style_left = 0;
	int rx_hold_left = 0;

	keyed_entropy_word_derivation DUT (
		.clk(clk),
		.arst_n(arst_n),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata(s_tdata),
		.s_tuser(s_tuser),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata(m_tdata),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	always #4 clk = ~clk;

	function automatic logic [63:0] rot_left(input logic [63:0] x, input int n);
		logic [127:0] twice;
		twice = {x, x} << n;
		return twice[127:64];
	endfunction

	function automatic logic [255:0] sip_mix(input logic [255:0] s);
		logic [63:0] a, b, c, d;
		{a, b, c, d} = s;
		a = a + b; b = rot_left(b, 13); b = b ^ a; a = rot_left(a, 32);
		c = c + d; d = rot_left(d, 16); d = d ^ c;
		a = a + d; d = rot_left(d, 21); d = d ^ a;
		c = c + b; b = rot_left(b, 17); b = b ^ c; c = rot_left(c, 32);
		return {a, b, c, d};
	endfunction

	function automatic logic [255:0] sip_absorb(input logic [255:0] s, input logic [63:0] m);
		logic [255:0] t;
		t = s ^ {192'd0, m};
		t = sip_mix(sip_mix(t));
		return t ^ {m, 192'd0};
	endfunction

	function automatic logic [63:0] siphash_word(input logic [63:0] msg, input logic [63:0] k0,
			input logic [63:0] k1);
		logic [255:0] s;
		s = {k0 ^ IV0, k1 ^ IV1, k0 ^ IV2, k1 ^ IV3};
		s = sip_absorb(s, msg);
		s = sip_absorb(s, LENGTH_BLOCK);
		s = s ^ {128'd0, FINAL_XOR, 64'd0};
		for (int r = 0; r < 4; r++) begin
			s = sip_mix(s);
		end
		return s[255:192] ^ s[191:128] ^ s[127:64] ^ s[63:0];
	endfunction

	function automatic entropy_t derive_entropy(input beacon_t b);
		entropy_t e;
		if (cfg_keyed) begin
			e.word = siphash_word({b.phase_bits, b.tick}, cfg_k0, cfg_k1);
		end else begin
			e.word = {32'd0, b.tick} ^ {b.phase_bits, 32'd0} ^ {32'd0, b.phase_bits};
		end
		e.credit = b.locked ? CREDIT_HI : CREDIT_LO;
		return e;
	endfunction

	task automatic set_reg(input logic [1:0] idx, input logic [63:0] val);
		@(posedge clk);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		@(posedge clk);
		cfg_we <= 1'b0;
		case (idx)
			kewd_pkg::REG_KEYED_MODE: cfg_keyed = val[0];
			kewd_pkg::REG_KEY_LOW: cfg_k0 = val;
			kewd_pkg::REG_KEY_HIGH: cfg_k1 = val;
			default: ;
		endcase
	endtask

	task automatic queue_beacon(input logic [31:0] tick, input logic [31:0] phase_bits,
			input logic locked);
		beacon_t b;
		b.tick = tick;
		b.phase_bits = phase_bits;
		b.locked = locked;
		beacon_q.push_back(b);
		beacons_queued++;
	endtask

	task automatic drain();
		while (words_seen < beacons_queued) begin
			@(posedge clk);
		end
	endtask

	// sender: bursts of random length separated by random gaps
	always @(posedge clk) begin
		if (!arst_n) begin
			s_tvalid <= 1'b0;
		end else begin
			if (s_tvalid && s_tready) begin
				entropy_expect_q.push_back(derive_entropy(beacon_cur));
			end
			if (!s_tvalid || s_tready) begin
				if (gap_left > 0 || beacon_q.size() == 0) begin
					if (gap_left > 0)
						gap_left--;
					s_tvalid <= 1'b0;
				end else begin
					beacon_cur = beacon_q.pop_front();
					s_tdata <= {beacon_cur.phase_bits, beacon_cur.tick};
					s_tuser <= beacon_cur.locked;
					s_tvalid <= 1'b1;
					if (burst_left > 0) begin
						burst_left--;
					end else begin
						burst_left = $urandom_range(0, 3) == 0 ? $urandom_range(50, 200)
							: $urandom_range(0, 20);
						gap_left = $urandom_range(0, 2) == 0 ? 0 : $urandom_range(1, 12);
					end
				end
			end
		end
	end

	// receiver: switches among random stall styles
	always @(posedge clk) begin
		if (!arst_n) begin
			m_tready <= 1'b0;
		end else begin
			if (rx_style_left == 0) begin
				rx_style = rx_style_t'($urandom_range(0, 3));
				rx_style_left = $urandom_range(32, 300);
			end else begin
				rx_style_left--;
			end
			case (rx_style)
				RX_OPEN: m_tready <= 1'b1;
				RX_COIN: m_tready <= ($urandom_range(0, 1) == 1);
				RX_SPARSE: m_tready <= ($urandom_range(0, 7) == 0);
				default: begin
					if (rx_hold_left == 0) begin
						m_tready <= ~m_tready;
						rx_hold_left = $urandom_range(0, 16);
					end else begin
						rx_hold_left--;
					end
				end
			endcase
		end
	end

	// result checker
	always @(posedge clk) begin
		entropy_t exp_e;
		if (arst_n && m_tvalid && m_tready) begin
			words_seen++;
			if (entropy_expect_q.size() == 0) begin
				$error("unexpected result transaction: %h", m_tdata);
				error_count++;
			end else begin
				exp_e = entropy_expect_q.pop_front();
				if (m_tdata[63:0] !== exp_e.word) begin
					$error("entropy_word expected %h actual %h", exp_e.word, m_tdata[63:0]);
					error_count++;
				end
				if (m_tdata[69:64] !== exp_e.credit) begin
					$error("credit_bits expected %0d actual %0d", exp_e.credit,
						m_tdata[69:64]);
					error_count++;
				end
			end
		end
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count == CYCLE_LIMIT) begin
			$display("keyed_entropy_word_derivation verification failed");
			$finish;
		end
	end

	initial begin
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;

		// bypass mode straight out of reset
		queue_beacon(32'h00000000, 32'h00000000, 1'b0);
		queue_beacon(32'hffffffff, 32'hffffffff, 1'b1);
		queue_beacon(32'hffffffff, 32'h00000000, 1'b0);
		queue_beacon(32'h00000000, 32'hffffffff, 1'b1);
		queue_beacon(32'haaaaaaaa, 32'h55555555, 1'b0);
		queue_beacon(32'h55555555, 32'haaaaaaaa, 1'b1);
		queue_beacon(32'h00000001, 32'h80000000, 1'b0);
		queue_beacon(32'h12345678, 32'h3f800000, 1'b1);
		drain();

		// unmapped index is ignored; stray mode bits are masked
		set_reg(REG_NONE, 64'hffffffffffffffff);
		set_reg(kewd_pkg::REG_KEYED_MODE, 64'hfffffffffffffffe);
		queue_beacon(32'hdeadbeef, 32'hcafef00d, 1'b1);
		queue_beacon(32'h00000000, 32'h00000000, 1'b0);
		drain();

		set_reg(kewd_pkg::REG_KEYED_MODE, 64'hffffffffffffffff);
		queue_beacon(32'h00000000, 32'h00000000, 1'b0);
		queue_beacon(32'hffffffff, 32'hffffffff, 1'b1);
		queue_beacon(32'h03020100, 32'h07060504, 1'b0);
		queue_beacon(32'h80000000, 32'h00000001, 1'b1);
		drain();

		set_reg(kewd_pkg::REG_KEY_LOW, 64'hffffffffffffffff);
		set_reg(kewd_pkg::REG_KEY_HIGH, 64'hffffffffffffffff);
		queue_beacon(32'h00000000, 32'h00000000, 1'b1);
		queue_beacon(32'hffffffff, 32'hffffffff, 1'b0);
		queue_beacon(32'h5a5a5a5a, 32'ha5a5a5a5, 1'b1);
		queue_beacon(32'h00000001, 32'h00000000, 1'b0);
		drain();

		for (int p = 0; p < 6; p++) begin
			case (p)
				0: begin
					set_reg(kewd_pkg::REG_KEY_LOW, 64'd0);
					set_reg(kewd_pkg::REG_KEY_HIGH, 64'hffffffffffffffff);
				end
				1: begin
					set_reg(kewd_pkg::REG_KEY_LOW, 64'hffffffffffffffff);
					set_reg(kewd_pkg::REG_KEY_HIGH, 64'd0);
				end
				default: begin
					set_reg(kewd_pkg::REG_KEY_LOW, {$urandom, $urandom});
					set_reg(kewd_pkg::REG_KEY_HIGH, {$urandom, $urandom});
				end
			endcase
			if (p == 2)
				set_reg(kewd_pkg::REG_KEYED_MODE, {$urandom, $urandom} & ~64'd1);
			else
				set_reg(kewd_pkg::REG_KEYED_MODE, {$urandom, $urandom} | 64'd1);
			for (int i = 0; i < RANDOM_PER_PHASE; i++) begin
				queue_beacon($urandom, $urandom, 1'($urandom_range(0, 1)));
			end
			drain();
		end

		repeat (TAIL_CYCLES) @(posedge clk);
		if (entropy_expect_q.size() != 0) begin
			$error("%0d expected results never arrived", entropy_expect_q.size());
			error_count++;
		end
		if (error_count == 0) begin
			$display("keyed_entropy_word_derivation verification clean");
		end else begin
			$display("keyed_entropy_word_derivation verification failed");
		end
		$finish;
	end

endmodule
